>>> hw/rtl/signed_add_sub_mul_div_unit_macros.svh
// Assertion macros shared by the ALU modules.
`ifndef SIGNED_ADD_SUB_MUL_DIV_UNIT_MACROS_SVH
`define SIGNED_ADD_SUB_MUL_DIV_UNIT_MACROS_SVH

// Same-cycle implication.
`define SASMD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication.
`define SASMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

>>> hw/rtl/sasmd_pkg.sv
// Shared types, constants and helpers for the signed ALU.
`timescale 1ns / 1ps

package sasmd_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int STEP_CNT_WIDTH = $clog2(DATA_WIDTH);
   localparam logic [STEP_CNT_WIDTH-1:0] LAST_STEP = STEP_CNT_WIDTH'(DATA_WIDTH - 1);

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
      logic [DATA_WIDTH-1:0] neg;
      neg = DATA_WIDTH'(~v + 1'b1);
      return v[DATA_WIDTH-1] ? neg : v;
   endfunction

   function automatic logic is_iterative(input action_type act);
      return (act == ACT_MUL) || (act == ACT_DIV);
   endfunction

endpackage

>>> hw/rtl/sasmd_datapath.sv
// Datapath: operand registers, shift-add multiplier and restoring divider.
`timescale 1ns / 1ps
`include "signed_add_sub_mul_div_unit_macros.svh"

module sasmd_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  sasmd_pkg::cmd_type                      cmd,
   input  logic [1:0]                              req_action,
   input  logic signed [sasmd_pkg::DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [sasmd_pkg::DATA_WIDTH-1:0] req_operand_b,
   output logic signed [sasmd_pkg::DATA_WIDTH-1:0] rsp_result,
   output logic                                    rsp_divide_by_zero
);

   localparam int DW = sasmd_pkg::DATA_WIDTH;

   sasmd_pkg::action_type action_in;
   sasmd_pkg::action_type action_ff;
   logic [DW-1:0] op_a;
   logic [DW-1:0] op_b;
   logic [DW-1:0] sum_ab;
   logic [DW-1:0] diff_ab;
   logic [DW-1:0] work_a_ff;
   logic [DW-1:0] work_b_ff;
   logic [DW:0]   acc_ff;
   logic [DW-1:0] quo_ff;
   logic          neg_ff;
   logic          dz_ff;
   logic [DW:0]   rem_shift;
   logic [DW:0]   den_ext;
   logic [DW:0]   rem_diff;
   logic          rem_ge;
   logic [DW-1:0] mul_sum;
   logic [DW-1:0] final_mag;
   logic [DW-1:0] final_val;
   logic [DW-1:0] rsp_result_ff;
   logic          rsp_dz_ff;

   assign action_in = sasmd_pkg::action_type'(req_action);
   assign op_a      = req_operand_a;
   assign op_b      = req_operand_b;
   assign sum_ab    = op_a + op_b;
   assign diff_ab   = op_a - op_b;

   // one restoring division step: shift in next dividend bit, try the divisor
   assign rem_shift = {acc_ff[DW-1:0], work_a_ff[DW-1]};
   assign den_ext   = {1'b0, work_b_ff};
   assign rem_ge    = rem_shift >= den_ext;
   assign rem_diff  = rem_shift - den_ext;

   assign mul_sum   = acc_ff[DW-1:0] + work_a_ff;

   assign final_mag = (action_ff == sasmd_pkg::ACT_DIV) ? quo_ff : acc_ff[DW-1:0];
   assign final_val = (sasmd_pkg::is_iterative(action_ff) && neg_ff) ?
                      DW'(~final_mag + 1'b1) : final_mag;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= action_in;
         work_a_ff <= sasmd_pkg::magnitude(op_a);
         work_b_ff <= sasmd_pkg::magnitude(op_b);
         quo_ff    <= '0;
         neg_ff    <= op_a[DW-1] ^ op_b[DW-1];
         dz_ff     <= (action_in == sasmd_pkg::ACT_DIV) && (op_b == '0);
         case (action_in)
            sasmd_pkg::ACT_ADD: acc_ff <= {1'b0, sum_ab};
            sasmd_pkg::ACT_SUB: acc_ff <= {1'b0, diff_ab};
            default:            acc_ff <= '0;
         endcase
      end else if (cmd.step) begin
         case (action_ff)
            sasmd_pkg::ACT_MUL: begin
               if (work_b_ff[0]) begin
                  acc_ff <= {1'b0, mul_sum};
               end
               work_a_ff <= {work_a_ff[DW-2:0], 1'b0};
               work_b_ff <= {1'b0, work_b_ff[DW-1:1]};
            end
            sasmd_pkg::ACT_DIV: begin
               acc_ff    <= rem_ge ? rem_diff : rem_shift;
               quo_ff    <= {quo_ff[DW-2:0], rem_ge};
               work_a_ff <= {work_a_ff[DW-2:0], 1'b0};
            end
            default: begin
               acc_ff <= acc_ff;
            end
         endcase
      end
      if (cmd.finish) begin
         rsp_result_ff <= dz_ff ? '0 : final_val;
         rsp_dz_ff     <= dz_ff;
      end
   end

   assign rsp_result         = rsp_result_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

   `SASMD_ASSERT_NEXT(a_dz_zero, clock, reset, cmd.finish && dz_ff, rsp_result_ff == '0)
   `SASMD_ASSERT_IMPL(a_step_act, clock, reset, cmd.step, sasmd_pkg::is_iterative(action_ff))

endmodule

>>> hw/rtl/sasmd_controller.sv
// Controller: sequences load, iteration and result strobe.
`timescale 1ns / 1ps
`include "signed_add_sub_mul_div_unit_macros.svh"

module sasmd_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_action,
   output logic               busy,
   output logic               rsp_valid,
   output sasmd_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_ITER = 3'b010,
      S_FIN  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic [sasmd_pkg::STEP_CNT_WIDTH-1:0] count_ff;
   logic [sasmd_pkg::STEP_CNT_WIDTH-1:0] count_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic iter_more;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               count_in = '0;
               // add and subtract are computed at load and skip the iteration state
               state_in = sasmd_pkg::is_iterative(sasmd_pkg::action_type'(req_action)) ?
                          S_ITER : S_FIN;
            end
         end
         S_ITER: begin
            cmd.step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == sasmd_pkg::LAST_STEP) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign iter_more = (state_ff == S_ITER) && (count_ff != sasmd_pkg::LAST_STEP);

   `SASMD_ASSERT_NEXT(a_fin_strobe, clock, reset, state_ff == S_FIN, rsp_valid_ff)
   `SASMD_ASSERT_IMPL(a_strobe_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE)
   `SASMD_ASSERT_NEXT(a_iter_hold, clock, reset, iter_more, state_ff == S_ITER)
   `SASMD_ASSERT_IMPL(a_onehot, clock, reset, 1'b1, $onehot(state_ff))

endmodule

>>> hw/rtl/signed_add_sub_mul_div_unit.sv
// Top level of the signed add / subtract / multiply / divide unit.
//
// Usage:
//   Drive req_action, req_operand_a and req_operand_b and raise start; the word
//   is taken at a clock edge where start is high and busy is low. Actions:
//   0 add, 1 subtract, 2 multiply, 3 divide (quotient truncated toward zero).
//   Exactly one result word follows: rsp_valid is high for one cycle with
//   rsp_result and rsp_divide_by_zero; the receiver must take it then, since
//   it cannot stall the unit. Dividing by zero gives 0 with the flag set.
//   Sequence after the accepting edge: add and subtract are computed at load,
//   then the finish state registers the result; multiply and divide run load,
//   32 steps of the shared shift-add / restoring-divide loop, one per operand
//   bit, then sign fix in the finish state. Busy drops in the strobe cycle,
//   so the next word may be accepted while the previous result is shown.
//   Reset (synchronous, active high) returns the controller to idle and
//   clears the strobe; an item in flight is dropped.
`timescale 1ns / 1ps

module signed_add_sub_mul_div_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_action,
   input  logic signed [sasmd_pkg::DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [sasmd_pkg::DATA_WIDTH-1:0] req_operand_b,
   output logic                                    rsp_valid,
   output logic signed [sasmd_pkg::DATA_WIDTH-1:0] rsp_result,
   output logic                                    rsp_divide_by_zero
);

   sasmd_pkg::cmd_type cmd;

   sasmd_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   sasmd_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_action         (req_action),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .rsp_result         (rsp_result),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule
